// ===== design/nvds_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// nvds_pkg
// Shared types and constants for the nearest value distance set core.
// ----------------------------------------------------------------------------
package nvds_pkg;

  localparam int VALUE_BITS   = 24;
  localparam int COST_BITS    = 25;
  localparam int TOTAL_BITS   = 48;
  localparam int CAPACITY_DEF = 1024;

  typedef logic signed [VALUE_BITS-1:0] value_t;
  typedef logic signed [COST_BITS-1:0]  cost_t;
  typedef logic        [COST_BITS-1:0]  dist_t;
  typedef logic signed [TOTAL_BITS-1:0] total_t;

  typedef struct packed {
    value_t new_value;
    logic   start_sequence;
  } in_item_t;

  typedef struct packed {
    cost_t  item_cost;
    total_t running_total;
    logic   store_full;
  } out_item_t;

  // control from the sequencer to the distance tracker
  typedef struct packed {
    logic clear;   // new item: reset the running minimum
    logic sample;  // read data from the store is valid this cycle
  } dist_ctrl_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DRAIN,
    ST_FINISH
  } state_t;

endpackage
`default_nettype wire

// ===== design/nearest_value_distance_set_core.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// nearest_value_distance_set_core
// Flow: accept, then the scan, drain and finish states, then the result
//   strobe; an empty store or a sequence start goes straight to finish.
// Throughput: a new item is taken only when idle, so each item waits on the
//   single store read port that visits every stored value.
// Reset: rst_n synchronous, clears count, total, sequencer; store contents stay.
// Results cannot be stalled: each sits on out_item for one cycle with out_strobe.
// ----------------------------------------------------------------------------
//
// The values live unsorted in a single-port-read memory. For each item the
// sequencer streams every stored entry through the distance tracker, which
// keeps the smallest |x - v|. That minimum equals the smaller of the
// predecessor and successor gaps. The value is then appended at the fill
// count, unless the store is full.
module nearest_value_distance_set_core #(
  parameter int CAPACITY = nvds_pkg::CAPACITY_DEF
) (
  input  wire                    clk,
  input  wire                    rst_n,
  input  wire                    start,
  output logic                   busy,
  input  nvds_pkg::in_item_t     in_item,
  output logic                   out_strobe,
  output nvds_pkg::out_item_t    out_item
);

  localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CW = $clog2(CAPACITY + 1);
  localparam logic [CW-1:0] CAP_CNT = CW'(CAPACITY);

  nvds_pkg::state_t     state_r, state_nxt;
  nvds_pkg::value_t     x_r, x_nxt;
  logic [AW-1:0]        scan_addr_r, scan_addr_nxt;
  logic [CW-1:0]        count_r, count_nxt;
  nvds_pkg::total_t     total_r, total_nxt;
  logic                 rd_valid_r, rd_valid_nxt;
  logic                 out_strobe_r, out_strobe_nxt;
  nvds_pkg::out_item_t  out_item_r, out_item_nxt;

  logic                 rd_en;
  logic                 wr_en;
  nvds_pkg::value_t     rd_data;
  nvds_pkg::dist_t      min_dist;
  nvds_pkg::dist_ctrl_t dctrl;
  nvds_pkg::cost_t      cost;
  logic                 full;
  logic [CW-1:0]        eff_count;

  nvds_store #(
    .DEPTH (CAPACITY),
    .AW    (AW)
  ) u_store (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (count_r[AW-1:0]),
    .wr_data (x_r),
    .rd_en   (rd_en),
    .rd_addr (scan_addr_r),
    .rd_data (rd_data)
  );

  nvds_dist u_dist (
    .clk      (clk),
    .ctrl     (dctrl),
    .query    (x_r),
    .stored   (rd_data),
    .min_dist (min_dist)
  );

  // First item of a sequence, or an empty store: cost is the value itself.
  assign cost = (count_r == '0)
              ? nvds_pkg::cost_t'({x_r[nvds_pkg::VALUE_BITS-1], x_r})
              : nvds_pkg::cost_t'(min_dist);
  assign full = (count_r == CAP_CNT);
  assign eff_count = in_item.start_sequence ? '0 : count_r;

  always_comb begin
    state_nxt      = state_r;
    x_nxt          = x_r;
    scan_addr_nxt  = scan_addr_r;
    count_nxt      = count_r;
    total_nxt      = total_r;
    out_strobe_nxt = 1'b0;
    out_item_nxt   = out_item_r;
    rd_en          = 1'b0;
    wr_en          = 1'b0;
    dctrl.clear    = 1'b0;
    dctrl.sample   = rd_valid_r;
    busy           = (state_r != nvds_pkg::ST_IDLE);

    case (state_r)
      nvds_pkg::ST_IDLE: begin
        if (start) begin
          // latch the item; a sequence start drops the store and total
          x_nxt         = in_item.new_value;
          scan_addr_nxt = '0;
          dctrl.clear   = 1'b1;
          if (in_item.start_sequence) begin
            count_nxt = '0;
            total_nxt = '0;
          end
          state_nxt = (eff_count == '0) ? nvds_pkg::ST_FINISH : nvds_pkg::ST_SCAN;
        end
      end
      nvds_pkg::ST_SCAN: begin
        // issue one read per cycle over all stored entries
        rd_en = 1'b1;
        if (CW'(scan_addr_r) == (count_r - CW'(1))) begin
          state_nxt = nvds_pkg::ST_DRAIN;
        end else begin
          scan_addr_nxt = scan_addr_r + AW'(1);
        end
      end
      nvds_pkg::ST_DRAIN: begin
        // last read data lands in the tracker this cycle
        state_nxt = nvds_pkg::ST_FINISH;
      end
      nvds_pkg::ST_FINISH: begin
        total_nxt = total_r
                  + nvds_pkg::total_t'({{(nvds_pkg::TOTAL_BITS - nvds_pkg::COST_BITS)
                                         {cost[nvds_pkg::COST_BITS-1]}}, cost});
        // append unless full; a full store drops the value
        if (!full) begin
          wr_en     = 1'b1;
          count_nxt = count_r + CW'(1);
        end
        out_item_nxt.item_cost     = cost;
        out_item_nxt.running_total = total_nxt;
        out_item_nxt.store_full    = full;
        out_strobe_nxt             = 1'b1;
        state_nxt                  = nvds_pkg::ST_IDLE;
      end
      default: begin
        state_nxt = nvds_pkg::ST_IDLE;
      end
    endcase
  end

  assign rd_valid_nxt = rd_en;

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= nvds_pkg::ST_IDLE;
      count_r      <= '0;
      total_r      <= '0;
      rd_valid_r   <= 1'b0;
      out_strobe_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      count_r      <= count_nxt;
      total_r      <= total_nxt;
      rd_valid_r   <= rd_valid_nxt;
      out_strobe_r <= out_strobe_nxt;
    end
  end

  // payload
  always_ff @(posedge clk) begin
    x_r         <= x_nxt;
    scan_addr_r <= scan_addr_nxt;
    out_item_r  <= out_item_nxt;
  end

  assign out_strobe = out_strobe_r;
  assign out_item   = out_item_r;

`ifndef SYNTHESIS
  a_strobe_single: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |=> !out_strobe)
    else $error("result strobe held for more than one cycle");

  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy)
    else $error("accepted item did not make the core busy");

  a_result_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> !busy)
    else $error("result shown while the core is still working");

  a_scan_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == nvds_pkg::ST_SCAN) |-> (count_r != '0))
    else $error("scan started over an empty store");

  a_full_count: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && out_item.store_full) |-> (count_r == CAP_CNT))
    else $error("store_full flagged with room left");
`endif

endmodule
`default_nettype wire

// ===== design/nvds_store.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// nvds_store
// Value store: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module nvds_store #(
  parameter int DEPTH = nvds_pkg::CAPACITY_DEF,
  parameter int AW    = $clog2(DEPTH)
) (
  input  wire                   clk,
  input  wire                   wr_en,
  input  wire  [AW-1:0]         wr_addr,
  input  nvds_pkg::value_t      wr_data,
  input  wire                   rd_en,
  input  wire  [AW-1:0]         rd_addr,
  output nvds_pkg::value_t      rd_data
);

  nvds_pkg::value_t mem [DEPTH];
  nvds_pkg::value_t rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule
`default_nettype wire

// ===== design/nvds_dist.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// nvds_dist
// Running minimum of the absolute distance between the query value and each
// stored value streamed out of the store.
// ----------------------------------------------------------------------------
module nvds_dist (
  input  wire                   clk,
  input  nvds_pkg::dist_ctrl_t  ctrl,
  input  nvds_pkg::value_t      query,
  input  nvds_pkg::value_t      stored,
  output nvds_pkg::dist_t       min_dist
);

  nvds_pkg::dist_t min_r;
  nvds_pkg::dist_t min_nxt;
  nvds_pkg::cost_t diff;
  nvds_pkg::dist_t abs_diff;

  // x - v never overflows one extra bit
  assign diff = nvds_pkg::cost_t'({query[nvds_pkg::VALUE_BITS-1], query})
              - nvds_pkg::cost_t'({stored[nvds_pkg::VALUE_BITS-1], stored});
  assign abs_diff = diff[nvds_pkg::COST_BITS-1] ? nvds_pkg::dist_t'(-diff)
                                                 : nvds_pkg::dist_t'(diff);

  always_comb begin
    min_nxt = min_r;
    if (ctrl.clear) begin
      min_nxt = '1;
    end else if (ctrl.sample && (abs_diff < min_r)) begin
      min_nxt = abs_diff;
    end
  end

  always_ff @(posedge clk) begin
    min_r <= min_nxt;
  end

  assign min_dist = min_r;

endmodule
`default_nettype wire
